// ===== design/hof_pkg.sv =====
// shared constants for the hann overlap framer
package hof_pkg;

  // width of the frame position field on the result channel
  localparam int POS_W = 9;

  // fixed point format used while building the window table
  localparam int Q_BITS = 30;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // sine taylor series: number of terms past the first and their divisors
  localparam int TAYLOR_TERMS = 7;
  localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
  };

endpackage

// ===== design/hof_sample_if.sv =====
// sample input channel
interface hof_sample_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

// ===== design/hof_frame_if.sv =====
// frame result channel
interface hof_frame_if #(
  parameter int SAMPLE_BITS = 16
);
  import hof_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [POS_W-1:0]              frame_position;
  logic signed [SAMPLE_BITS-1:0] frame_value;
  logic                          frame_last;

  modport source (output valid, output frame_position, output frame_value,
                  output frame_last, input ready);
  modport sink (input valid, input frame_position, input frame_value,
                input frame_last, output ready);
endinterface

// ===== design/hof_front.sv =====
// front end: accepts samples, tracks mode and chunk position, builds commands
module hof_front #(
  parameter int FRAME_SIZE  = 512,
  parameter int SAMPLE_BITS = 16,
  parameter int CMD_W       = 3 + $clog2(FRAME_SIZE) + SAMPLE_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  hof_sample_if.sink       sample,
  output logic             push,
  output logic [CMD_W-1:0] push_data,
  input  logic             push_ready
);

  localparam int HALF = FRAME_SIZE / 2;
  localparam int CW   = $clog2(FRAME_SIZE);
  localparam int FW   = $clog2(HALF + 1);

  typedef struct packed {
    logic                          pass;
    logic                          prev_ok;
    logic                          last;
    logic [CW-1:0]                 k;
    logic signed [SAMPLE_BITS-1:0] val;
  } cmd_t;

  logic          mode;
  logic [CW-1:0] counter;
  // entries below fill have been written since reset, the rest read as zero
  logic [FW-1:0] fill;
  logic          accept;
  logic          last;
  cmd_t          cmd;

  assign accept       = sample.valid && push_ready;
  assign sample.ready = push_ready;
  assign push         = accept;

  assign last = mode ? (counter == CW'(FRAME_SIZE - 1)) : (counter == CW'(HALF - 1));

  always_comb begin
    cmd.pass    = mode;
    cmd.prev_ok = (counter < CW'(fill));
    cmd.last    = last;
    cmd.k       = counter;
    cmd.val     = mode ? sample.sample_in : (sample.sample_in >>> 1);
  end

  assign push_data = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= 1'b0;
      counter <= '0;
      fill    <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_wr_data != mode) begin
        mode    <= cfg_wr_data;
        counter <= '0;
      end
    end else if (accept) begin
      counter <= last ? '0 : counter + 1'b1;
      if (!mode && (CW'(fill) == counter)) begin
        fill <= fill + 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(HALF))
    else $error("fill count past half frame");

  a_counter_bound: assert property (@(posedge clk) disable iff (rst)
    mode ? (counter < CW'(FRAME_SIZE - 1) || counter == CW'(FRAME_SIZE - 1))
         : (counter < CW'(HALF)))
    else $error("chunk counter out of range for mode");
`endif

endmodule

// ===== design/hof_queue.sv =====
// small command queue between front and back
module hof_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             pop_valid
);

  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [NW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != NW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/hof_back.sv =====
// back end: half-frame store, window table, multiply, round and saturate
module hof_back #(
  parameter int FRAME_SIZE     = 512,
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 16,
  parameter int CMD_W          = 3 + $clog2(FRAME_SIZE) + SAMPLE_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  logic [CMD_W-1:0] q_data,
  output logic             q_pop,
  hof_frame_if.source      frame
);
  import hof_pkg::*;

  localparam int HALF   = FRAME_SIZE / 2;
  localparam int CW     = $clog2(FRAME_SIZE);
  localparam int HW     = $clog2(HALF);
  localparam int COEF_W = COEF_FRAC_BITS + 2;
  localparam int PROD_W = SAMPLE_BITS + COEF_W + 1;
  localparam int R_W    = PROD_W - COEF_FRAC_BITS;
  localparam int PW_EXT = CW + POS_W;
  localparam logic [63:0] D_LEN = 64'(FRAME_SIZE - 1);

  typedef struct packed {
    logic                          pass;
    logic                          prev_ok;
    logic                          last;
    logic [CW-1:0]                 k;
    logic signed [SAMPLE_BITS-1:0] val;
  } cmd_t;

  typedef logic [COEF_W-1:0] rom_t [FRAME_SIZE];

  // symmetric hann window normalized to unit mean, sine by taylor series
  function automatic rom_t build_rom();
    rom_t               rom;
    logic [63:0]        j;
    logic [63:0]        theta;
    logic [63:0]        th2;
    logic [63:0]        mag;
    logic [63:0]        s;
    logic [63:0]        s2;
    logic [63:0]        x;
    logic signed [63:0] sum;
    for (int i = 0; i < FRAME_SIZE; i++) begin
      j = (64'(i) < D_LEN - 64'(i)) ? 64'(i) : D_LEN - 64'(i);
      theta = (PI_Q30 * j) / D_LEN;
      th2 = (theta * theta) >> Q_BITS;
      mag = theta;
      sum = signed'(theta);
      for (int t = 1; t <= TAYLOR_TERMS; t++) begin
        mag = (mag * th2) >> Q_BITS;
        mag = mag / TAYLOR_DIV[t-1];
        if ((t % 2) == 1) begin
          sum = sum - signed'(mag);
        end else begin
          sum = sum + signed'(mag);
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      s = unsigned'(sum);
      s2 = (s * s) >> Q_BITS;
      x = (s2 * 64'(2 * FRAME_SIZE)) / D_LEN;
      rom[i] = COEF_W'((x + (64'd1 << (Q_BITS - 1 - COEF_FRAC_BITS)))
                       >> (Q_BITS - COEF_FRAC_BITS));
    end
    return rom;
  endfunction

  localparam rom_t WIN_ROM = build_rom();

  localparam logic [R_W-1:0] SAT_HI_R = R_W'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic [R_W-1:0] SAT_LO_R = SAT_HI_R + 1'b1;
  localparam logic [SAMPLE_BITS-1:0] VAL_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] VAL_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [PROD_W-1:0] RND = PROD_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic [POS_W-1:0] LAST_PASS_POS = POS_W'(FRAME_SIZE - 1);
  localparam logic [POS_W-1:0] LAST_HANN_POS = POS_W'(2 * HALF - 1);

  // half-frame store of halved samples
  logic signed [SAMPLE_BITS-1:0] mem [HALF];

  cmd_t          head;
  logic          adv;
  logic          phase;
  logic          final_op;
  logic          store_wr;
  logic [CW-1:0] op_pos;

  // stage 1: store and table reads
  logic                          s1_valid;
  logic                          s1_use_prev;
  logic                          s1_prev_ok;
  logic                          s1_pass;
  logic                          s1_last;
  logic [CW-1:0]                 s1_pos;
  logic signed [SAMPLE_BITS-1:0] s1_val;
  logic signed [SAMPLE_BITS-1:0] mem_q;
  logic [COEF_W-1:0]             rom_q;

  // stage 2: product
  logic                          s2_valid;
  logic                          s2_pass;
  logic                          s2_last;
  logic [CW-1:0]                 s2_pos;
  logic signed [SAMPLE_BITS-1:0] s2_val;
  logic signed [PROD_W-1:0]      s2_prod;

  // output register
  logic out_valid;

  logic signed [SAMPLE_BITS-1:0] opnd;
  logic signed [COEF_W:0]        coef_s;
  logic                          neg;
  logic [PROD_W-1:0]             mag;
  logic [PROD_W-1:0]             rnd_sum;
  logic [R_W-1:0]                r;
  logic [SAMPLE_BITS-1:0]        win_val;
  logic [PW_EXT-1:0]             pos_wide;

  assign head     = cmd_t'(q_data);
  assign adv      = !out_valid || frame.ready;
  assign final_op = head.pass || phase;
  assign q_pop    = adv && q_valid && final_op;
  // first op of a hann item reads the old entry and stores the new halved sample
  assign store_wr = adv && q_valid && !head.pass && !phase;
  assign op_pos   = (head.pass || !phase) ? head.k : head.k + CW'(HALF);

  always_ff @(posedge clk) begin
    if (adv) begin
      mem_q <= mem[head.k[HW-1:0]];
      rom_q <= WIN_ROM[op_pos];
      if (store_wr) begin
        mem[head.k[HW-1:0]] <= head.val;
      end
    end
  end

  always_comb begin
    opnd   = s1_use_prev ? (s1_prev_ok ? mem_q : '0) : s1_val;
    coef_s = signed'({1'b0, rom_q});
  end

  always_comb begin
    neg     = s2_prod[PROD_W-1];
    mag     = neg ? PROD_W'(-s2_prod) : PROD_W'(s2_prod);
    rnd_sum = mag + RND;
    r       = rnd_sum[PROD_W-1:COEF_FRAC_BITS];
    if (!neg) begin
      win_val = (r > SAT_HI_R) ? VAL_MAX : r[SAMPLE_BITS-1:0];
    end else begin
      win_val = (r > SAT_LO_R) ? VAL_MIN : SAMPLE_BITS'(-r[SAMPLE_BITS-1:0]);
    end
    pos_wide = PW_EXT'(s2_pos);
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_use_prev <= !head.pass && !phase;
      s1_prev_ok  <= head.prev_ok;
      s1_pass     <= head.pass;
      s1_last     <= final_op && head.last;
      s1_pos      <= op_pos;
      s1_val      <= head.val;

      s2_pass <= s1_pass;
      s2_last <= s1_last;
      s2_pos  <= s1_pos;
      s2_val  <= s1_val;
      s2_prod <= opnd * coef_s;

      frame.frame_position <= pos_wide[POS_W-1:0];
      frame.frame_value    <= s2_pass ? s2_val : signed'(win_val);
      frame.frame_last     <= s2_last;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      if (q_valid) begin
        phase <= head.pass ? 1'b0 : !phase;
      end
      s1_valid  <= q_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  assign frame.valid = out_valid;

`ifndef ASSERT_OFF
  a_phase_head: assert property (@(posedge clk) disable iff (rst)
    phase |-> q_valid)
    else $error("second hann op pending with no command at queue head");

  a_second_op: assert property (@(posedge clk) disable iff (rst)
    store_wr |=> phase)
    else $error("hann item did not move to its second op");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    (frame.valid && frame.frame_last) |->
      (frame.frame_position == LAST_PASS_POS || frame.frame_position == LAST_HANN_POS))
    else $error("frame end flagged at an inner position");
`endif

endmodule

// ===== design/hann_overlap_framer_top.sv =====
// top level of the hann overlap framer
//
// sample channel: one signed audio sample per transaction (valid/ready).
// frame channel: results with frame_position, frame_value and frame_last.
// cfg_wr_en/cfg_wr_data write window_mode (0 hann with half overlap,
// 1 passthrough); a write that changes the mode restarts the chunk at 0.
// hann mode: sample k of a chunk gives two results, the stored half-scaled
// sample times coefficient k, then the new half-scaled sample times
// coefficient HALF+k; frame_last marks the end of the chunk.
// passthrough: one result per sample at positions 0 .. FRAME_SIZE-1.
// both results of a hann sample share the one multiplier and the single
// output register in turn; each command passes the queue, the store and
// table read stage, the product stage and then the output register.
// a 4-entry command queue sits between front and back, so samples are
// taken while results wait; a stalled receiver freezes the back pipeline
// and sample ready drops once the queue fills.
// reset clears mode, chunk counter and queue; the half-frame store reads
// as zero until each entry is first written, no clearing pass is needed.
module hann_overlap_framer_top #(
  parameter int FRAME_SIZE     = 512,
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  hof_sample_if.sink  sample,
  hof_frame_if.source frame
);

  localparam int CMD_W = 3 + $clog2(FRAME_SIZE) + SAMPLE_BITS;

  logic             push;
  logic [CMD_W-1:0] push_data;
  logic             push_ready;
  logic             pop;
  logic [CMD_W-1:0] pop_data;
  logic             pop_valid;

  hof_front #(
    .FRAME_SIZE  (FRAME_SIZE),
    .SAMPLE_BITS (SAMPLE_BITS),
    .CMD_W       (CMD_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .sample      (sample),
    .push        (push),
    .push_data   (push_data),
    .push_ready  (push_ready)
  );

  hof_queue #(
    .WIDTH (CMD_W),
    .DEPTH (4)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_data   (pop_data),
    .pop_valid  (pop_valid)
  );

  hof_back #(
    .FRAME_SIZE     (FRAME_SIZE),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .CMD_W          (CMD_W)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (pop_valid),
    .q_data  (pop_data),
    .q_pop   (pop),
    .frame   (frame)
  );

endmodule
